/* design/sbes_pkg.sv */
// Shared types and constants for the sliding bin extremum search block.
// Used by the register file, controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps

package sbes_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 24;
  localparam int RES_W    = POS_W + 1;
  localparam int BIN_W    = 9;
  localparam int MODE_W   = 2;

  // APB-style register port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // search_mode bits: bit 1 selects max, bit 0 selects index output
  localparam int MODE_MAX_BIT   = 1;
  localparam int MODE_INDEX_BIT = 0;

  typedef enum logic [1:0] {
    REG_SEARCH_MODE  = 2'd0,
    REG_BIN_WIDTH    = 2'd1,
    REG_START_OFFSET = 2'd2,
    REG_RANGE_WIDTH  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_SUM_END,
    ST_DIV_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_beat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic                    window_found;
  } out_beat_t;

  // Live configuration, bin width already clamped to the usable range
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BIN_W-1:0]  bin;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  range_w;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic resum;
    logic sum_issue;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic sum_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

/* design/sbes_regs.sv */
// Configuration register file behind the APB-style port.
// Depends on sbes_pkg for widths, register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module sbes_regs #(
  parameter int MAX_BIN = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sbes_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sbes_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sbes_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output sbes_pkg::cfg_t              cfg,
  output logic                        bin_wr
);

  logic [sbes_pkg::MODE_W-1:0] mode_r;
  logic [sbes_pkg::BIN_W-1:0]  bin_size_r;
  logic [sbes_pkg::POS_W-1:0]  offset_r;
  logic [sbes_pkg::POS_W-1:0]  range_r;
  logic                        wr_en;
  sbes_pkg::reg_idx_t          idx;
  logic [sbes_pkg::BIN_W-1:0]  bin_eff;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = sbes_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign bin_wr     = wr_en && (idx == sbes_pkg::REG_BIN_WIDTH);

  // Write registers on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= '0;
      bin_size_r <= sbes_pkg::BIN_W'(1);
      offset_r   <= '0;
      range_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        sbes_pkg::REG_SEARCH_MODE:  mode_r     <= cfg_pwdata[sbes_pkg::MODE_W-1:0];
        sbes_pkg::REG_BIN_WIDTH:    bin_size_r <= cfg_pwdata[sbes_pkg::BIN_W-1:0];
        sbes_pkg::REG_START_OFFSET: offset_r   <= cfg_pwdata[sbes_pkg::POS_W-1:0];
        sbes_pkg::REG_RANGE_WIDTH:  range_r    <= cfg_pwdata[sbes_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      sbes_pkg::REG_SEARCH_MODE:  cfg_prdata = sbes_pkg::CFG_DW'(mode_r);
      sbes_pkg::REG_BIN_WIDTH:    cfg_prdata = sbes_pkg::CFG_DW'(bin_size_r);
      sbes_pkg::REG_START_OFFSET: cfg_prdata = sbes_pkg::CFG_DW'(offset_r);
      sbes_pkg::REG_RANGE_WIDTH:  cfg_prdata = sbes_pkg::CFG_DW'(range_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // Clamp bin width: zero acts as one, oversize acts as the line depth
  always_comb begin
    if (bin_size_r == '0) begin
      bin_eff = sbes_pkg::BIN_W'(1);
    end else if (int'(bin_size_r) > MAX_BIN) begin
      bin_eff = sbes_pkg::BIN_W'(MAX_BIN);
    end else begin
      bin_eff = bin_size_r;
    end
  end

  assign cfg.mode    = mode_r;
  assign cfg.bin     = bin_eff;
  assign cfg.offset  = offset_r;
  assign cfg.range_w = range_r;

endmodule

/* design/sbes_ctrl.sv */
// Sequencing state machine: accept, update, re-sum, divide and output.
// Depends on sbes_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module sbes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              bin_wr,
  input  sbes_pkg::status_t status,
  output sbes_pkg::cmd_t    cmd
);

  sbes_pkg::state_t state_r, state_nxt;
  logic             dirty_r, dirty_nxt;

  // State and re-sum flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbes_pkg::ST_IDLE;
      dirty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r | bin_wr;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      sbes_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sbes_pkg::ST_UPDATE;
        end
      end
      sbes_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.last) begin
          state_nxt = sbes_pkg::ST_DIV_LOAD;
        end else if (dirty_r) begin
          // bin width changed: rebuild the window sum from the line
          cmd.resum = 1'b1;
          dirty_nxt = 1'b0;
          state_nxt = sbes_pkg::ST_SUM;
        end else begin
          state_nxt = sbes_pkg::ST_IDLE;
        end
      end
      sbes_pkg::ST_SUM: begin
        cmd.sum_issue = 1'b1;
        if (status.sum_last) begin
          state_nxt = sbes_pkg::ST_SUM_END;
        end
      end
      sbes_pkg::ST_SUM_END: begin
        state_nxt = sbes_pkg::ST_IDLE;
      end
      sbes_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = sbes_pkg::ST_DIV;
      end
      sbes_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = sbes_pkg::ST_OUT;
        end
      end
      sbes_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          dirty_nxt    = 1'b0;
          state_nxt    = sbes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbes_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/sbes_datapath.sv */
// Datapath: sample line memory, running window sum, best-window tracking,
// serial divider and output register. Depends on sbes_pkg.
`timescale 1ns / 1ps

module sbes_datapath #(
  parameter int MAX_BIN = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbes_pkg::cfg_t      cfg,
  input  sbes_pkg::cmd_t      cmd,
  input  sbes_pkg::in_beat_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output sbes_pkg::out_beat_t out_data,
  output sbes_pkg::status_t   status
);

  localparam int AW    = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
  localparam int SUM_W = sbes_pkg::SAMPLE_W + $clog2(MAX_BIN) + 1;
  localparam int DW    = ((AW > sbes_pkg::BIN_W) ? AW : sbes_pkg::BIN_W) + 1;
  localparam int IW    = sbes_pkg::POS_W + 2;
  localparam int PW    = sbes_pkg::POS_W + 1;
  localparam int QW    = (SUM_W + 1 > sbes_pkg::RES_W) ? SUM_W + 1 : sbes_pkg::RES_W;
  localparam int CW    = $clog2(SUM_W);
  localparam logic [sbes_pkg::POS_W-1:0] POS_MAX = '1;
  localparam logic [AW-1:0]              LAST_SLOT = AW'(MAX_BIN - 1);

  // Sample line
  logic signed [sbes_pkg::SAMPLE_W-1:0] line_mem [MAX_BIN];
  logic signed [sbes_pkg::SAMPLE_W-1:0] rd_r;
  logic [AW-1:0]                        ra;
  logic [AW-1:0]                        leave_addr;
  logic [DW-1:0]                        leave_diff;

  // Current item
  logic signed [sbes_pkg::SAMPLE_W-1:0] x_r;
  logic                                 last_r;
  logic [sbes_pkg::POS_W-1:0]           p_item_r;
  logic [AW-1:0]                        wptr_item_r;
  logic                                 leave_inc_r;

  // Channel state
  logic [sbes_pkg::POS_W-1:0]  position_r;
  logic [AW-1:0]               wptr_r;
  logic                        sat_r;
  logic signed [SUM_W-1:0]     window_sum_r;
  logic signed [SUM_W-1:0]     best_sum_r;
  logic [sbes_pkg::RES_W-1:0]  best_idx_r;
  logic                        have_r;
  logic                        pend_r;

  // Re-sum sweep
  logic [AW-1:0]              rptr_r;
  logic [sbes_pkg::BIN_W-1:0] kcnt_r;
  logic                       acc_v_r;

  // Divider
  logic [SUM_W-1:0]           dq_r;
  logic [sbes_pkg::BIN_W-1:0] rem_r;
  logic                       neg_r;
  logic [CW-1:0]              dcnt_r;
  logic [sbes_pkg::BIN_W:0]   trial;
  logic [sbes_pkg::BIN_W:0]   trial_sub;
  logic                       trial_ge;

  // Output register
  logic                out_valid_r;
  sbes_pkg::out_beat_t out_data_r;

  // Update-cycle terms
  logic signed [SUM_W-1:0]    run_sum;
  logic signed [SUM_W-1:0]    leave_val;
  logic                       better;
  logic [IW-1:0]              s_idx;
  logic [PW-1:0]              p1;
  logic [PW-1:0]              st;
  logic                       cand_ok;
  logic [SUM_W-1:0]           mag;
  logic signed [QW-1:0]       quo_s;
  logic                       find_max;

  assign find_max = cfg.mode[sbes_pkg::MODE_MAX_BIT];

  // Slot that drops out of the window; once saturated the same slot is replaced
  always_comb begin
    leave_diff = DW'(wptr_r) - DW'(cfg.bin);
    if (leave_diff[DW-1]) begin
      leave_diff = leave_diff + DW'(MAX_BIN);
    end
    leave_addr = sat_r ? wptr_r : leave_diff[AW-1:0];
    ra         = cmd.sum_issue ? rptr_r : leave_addr;
  end

  // Line memory: read old data before the write lands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      line_mem[wptr_r] <= in_data.sample;
    end
    rd_r <= line_mem[ra];
  end

  // Running sum, confirmation of the pending window, next candidate
  always_comb begin
    leave_val = leave_inc_r ? SUM_W'(rd_r) : '0;
    run_sum   = window_sum_r + SUM_W'(x_r) - leave_val;
    better    = !have_r || (find_max ? (window_sum_r > best_sum_r)
                                     : (window_sum_r < best_sum_r));
    s_idx     = IW'(p_item_r) - IW'(cfg.bin) - IW'(cfg.bin >> 1);
    p1        = PW'(p_item_r) + PW'(1);
    st        = p1 - PW'(cfg.bin);
    cand_ok   = (p_item_r != POS_MAX) && (p1 >= PW'(cfg.bin))
             && (st >= PW'(cfg.offset))
             && ((cfg.range_w == '0) || (p1 < PW'(cfg.offset) + PW'(cfg.range_w)));
  end

  // Divider step: restoring, one quotient bit per cycle
  always_comb begin
    trial     = {rem_r, dq_r[SUM_W-1]};
    trial_sub = trial - {1'b0, cfg.bin};
    trial_ge  = trial >= {1'b0, cfg.bin};
    mag       = best_sum_r[SUM_W-1] ? SUM_W'(-best_sum_r) : SUM_W'(best_sum_r);
    quo_s     = neg_r ? -$signed(QW'({1'b0, dq_r})) : $signed(QW'({1'b0, dq_r}));
  end

  // Capture the accepted beat and advance the write position
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r         <= in_data.sample;
      last_r      <= in_data.last;
      p_item_r    <= position_r;
      wptr_item_r <= wptr_r;
      leave_inc_r <= sat_r || (sbes_pkg::POS_W'(cfg.bin) <= position_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      wptr_r     <= '0;
      sat_r      <= 1'b0;
    end else if (cmd.out_load) begin
      position_r <= '0;
      wptr_r     <= '0;
      sat_r      <= 1'b0;
    end else if (cmd.accept) begin
      if (position_r != POS_MAX) begin
        position_r <= position_r + 1'b1;
        wptr_r     <= (wptr_r == LAST_SLOT) ? '0 : wptr_r + 1'b1;
      end else begin
        sat_r <= 1'b1;
      end
    end
  end

  // Window sum: running update, or a rebuild sweep after a bin width change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_sum_r <= '0;
    end else if (cmd.out_load) begin
      window_sum_r <= '0;
    end else if (cmd.update) begin
      window_sum_r <= cmd.resum ? '0 : run_sum;
    end else if (acc_v_r) begin
      window_sum_r <= window_sum_r + SUM_W'(rd_r);
    end
  end

  // Rebuild sweep: newest slot first, skip slots not yet written this channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= cmd.sum_issue && (sbes_pkg::POS_W'(kcnt_r) <= p_item_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resum) begin
      rptr_r <= wptr_item_r;
      kcnt_r <= '0;
    end else if (cmd.sum_issue) begin
      rptr_r <= (rptr_r == '0) ? LAST_SLOT : rptr_r - 1'b1;
      kcnt_r <= kcnt_r + 1'b1;
    end
  end

  // Best window tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sum_r <= '0;
      best_idx_r <= '0;
      have_r     <= 1'b0;
      pend_r     <= 1'b0;
    end else if (cmd.out_load) begin
      best_sum_r <= '0;
      best_idx_r <= '0;
      have_r     <= 1'b0;
      pend_r     <= 1'b0;
    end else if (cmd.update) begin
      if (pend_r && better) begin
        best_sum_r <= window_sum_r;
        best_idx_r <= s_idx[sbes_pkg::RES_W-1:0];
        have_r     <= 1'b1;
      end
      pend_r <= cand_ok;
    end
  end

  // Mean divider
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq_r   <= mag;
      neg_r  <= best_sum_r[SUM_W-1];
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dq_r   <= {dq_r[SUM_W-2:0], trial_ge};
      rem_r  <= trial_ge ? trial_sub[sbes_pkg::BIN_W-1:0] : trial[sbes_pkg::BIN_W-1:0];
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Output register: load the result, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.window_found <= have_r;
      if (!have_r) begin
        out_data_r.result <= '0;
      end else if (cfg.mode[sbes_pkg::MODE_INDEX_BIT]) begin
        out_data_r.result <= best_idx_r;
      end else begin
        out_data_r.result <= quo_s[sbes_pkg::RES_W-1:0];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.last     = last_r;
  assign status.sum_last = (kcnt_r == cfg.bin - 1'b1);
  assign status.div_done = (dcnt_r == CW'(SUM_W - 1));
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

/* design/sliding_bin_extremum_search.sv */
// Sliding bin extremum search: one signed sample per beat; on the last sample
// of a channel it returns the mean or index of the smallest or largest window
// sum in the analysis range. A sample that does not end a channel is accepted,
// then used in a running-sum update through the single read port of the sample
// line. The first such sample after a write to the bin size register also
// rebuilds the window sum from the line, one slot per cycle. A last sample
// goes through the bit-serial divider for the mean, one quotient bit for each
// of the SUM_W bits (SUM_W = 17 + log2(MAX_BIN), 25 at the default), then waits
// for the output register to empty if need be. There is no clearing pass: slots
// not yet written in the current channel are masked by the sample count.
// Depends on sbes_pkg, sbes_regs, sbes_ctrl and sbes_datapath.
`timescale 1ns / 1ps

module sliding_bin_extremum_search #(
  parameter int MAX_BIN = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sbes_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sbes_pkg::out_beat_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sbes_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [sbes_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [sbes_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  sbes_pkg::cfg_t    cfg;
  sbes_pkg::cmd_t    cmd;
  sbes_pkg::status_t status;
  logic              bin_wr;

  sbes_regs #(
    .MAX_BIN (MAX_BIN)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .bin_wr      (bin_wr)
  );

  sbes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .bin_wr   (bin_wr),
    .status   (status),
    .cmd      (cmd)
  );

  sbes_datapath #(
    .MAX_BIN (MAX_BIN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

`ifndef ASSERT_OFF
  // Every accepted beat is followed by its update cycle
  a_accept_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> cmd.update)
    else $error("accepted beat not followed by update");

  // A result is loaded only when the output register is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken beat");

  // Output valid rises only from a result load
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

  // No input is taken while the window sum is being rebuilt
  a_no_accept_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_issue |-> !cmd.accept)
    else $error("input accepted during re-sum sweep");
`endif

endmodule
